>>> rtl/dpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsm_pkg
// Shared types and constants for the dual pulse-skip modulator.
// ----------------------------------------------------------------------------
package dpsm_pkg;

  localparam int LEVEL_W = 8;
  localparam int TEMP_W  = 16;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request kinds
  localparam logic KIND_UPDATE    = 1'b0;
  localparam logic KIND_ZERO_CROSS = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOD_RANGE   = 2'd0,
    REG_TEMP_LIMIT  = 2'd1,
    REG_SENSOR_ERR  = 2'd2
  } cfg_reg_t;

  // reset values of the configuration registers
  localparam logic [LEVEL_W-1:0] RANGE_RST      = 8'h7F;
  localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RST = 16'd1200;
  localparam logic [TEMP_W-1:0]  SENSOR_ERR_RST = 16'hFFFF;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [LEVEL_W-1:0] mod_range;
    logic [TEMP_W-1:0]  temp_limit;
    logic [TEMP_W-1:0]  sensor_err;
  } cfg_t;

  // result of one accumulate-and-compare step
  typedef struct packed {
    logic [LEVEL_W-1:0] accum;
    logic               skip;
  } chan_res_t;

endpackage

>>> rtl/dpsm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsm_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module dpsm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dpsm_pkg::cfg_t                   cfg
);

  dpsm_pkg::cfg_t cfg_r;

  // always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes, unused index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mod_range  <= dpsm_pkg::RANGE_RST;
      cfg_r.temp_limit <= dpsm_pkg::TEMP_LIMIT_RST;
      cfg_r.sensor_err <= dpsm_pkg::SENSOR_ERR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpsm_pkg::REG_MOD_RANGE:  cfg_r.mod_range  <= cfg_data[dpsm_pkg::LEVEL_W-1:0];
        dpsm_pkg::REG_TEMP_LIMIT: cfg_r.temp_limit <= cfg_data;
        dpsm_pkg::REG_SENSOR_ERR: cfg_r.sensor_err <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/dpsm_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsm_chan
// One pulse-skip channel step: accumulate, compare against range, wrap.
// ----------------------------------------------------------------------------
module dpsm_chan (
  input  logic [dpsm_pkg::LEVEL_W-1:0] accum,
  input  logic [dpsm_pkg::LEVEL_W-1:0] level,
  input  logic [dpsm_pkg::LEVEL_W-1:0] mod_range,
  output dpsm_pkg::chan_res_t          res
);

  logic [dpsm_pkg::LEVEL_W:0] sum;
  logic [dpsm_pkg::LEVEL_W:0] range_ext;
  logic [dpsm_pkg::LEVEL_W:0] rem;
  logic                       reached;

  // full-width sum, one bit of headroom
  assign sum       = {1'b0, accum} + {1'b0, level};
  assign range_ext = {1'b0, mod_range};
  assign reached   = (sum >= range_ext);
  assign rem       = reached ? (sum - range_ext) : sum;

  // a remainder still above range is dropped and the channel fires
  always_comb begin
    if (rem > range_ext) begin
      res.accum = '0;
      res.skip  = 1'b0;
    end else begin
      res.accum = rem[dpsm_pkg::LEVEL_W-1:0];
      res.skip  = !reached;
    end
  end

endmodule

>>> rtl/dual_pulse_skip_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pulse_skip_modulator
// Pump and heater pulse-skip modulator driven by update and zero-crossing
// requests; one result request per input request.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in_       in_valid/in_stall  kind, pump_level, heater_level, heater_temp,
//                               clear_count
//  out_      out_valid/out_stall pump_skip, heater_skip, pump_fire_count
//  cfg_      cfg_valid/cfg_ready index, data
//
//  One request per cycle unless stalled; its result enters the output
//  register after acceptance, set by the single accumulate-compare stage.
//  Synchronous active-low reset clears state, pins to off, config to defaults.
//  in_stall follows out_stall while a result is held in the output register.
// ----------------------------------------------------------------------------
module dual_pulse_skip_modulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [dpsm_pkg::LEVEL_W-1:0]     in_pump_level,
  input  logic [dpsm_pkg::LEVEL_W-1:0]     in_heater_level,
  input  logic [dpsm_pkg::TEMP_W-1:0]      in_heater_temp,
  input  logic                             in_clear_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pump_skip,
  output logic                             out_heater_skip,
  output logic [dpsm_pkg::COUNT_W-1:0]     out_pump_fire_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dpsm_pkg::cfg_t      cfg;
  dpsm_pkg::chan_res_t pump_res;
  dpsm_pkg::chan_res_t heat_res;

  logic [dpsm_pkg::LEVEL_W-1:0] pump_accum_r, pump_accum_nxt;
  logic [dpsm_pkg::LEVEL_W-1:0] heat_accum_r, heat_accum_nxt;
  logic [dpsm_pkg::LEVEL_W-1:0] pump_set_r, pump_set_nxt;
  logic [dpsm_pkg::LEVEL_W-1:0] heat_set_r, heat_set_nxt;
  logic [dpsm_pkg::COUNT_W-1:0] fires_r, fires_nxt;
  logic                         pump_pin_r, pump_pin_nxt;
  logic                         heat_pin_r, heat_pin_nxt;
  logic                         out_valid_r;
  logic                         out_pump_r, out_heat_r;
  logic [dpsm_pkg::COUNT_W-1:0] out_count_r;
  logic                         accept;

  dpsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpsm_chan u_pump (
    .accum     (pump_accum_r),
    .level     (pump_set_r),
    .mod_range (cfg.mod_range),
    .res       (pump_res)
  );

  dpsm_chan u_heat (
    .accum     (heat_accum_r),
    .level     (heat_set_r),
    .mod_range (cfg.mod_range),
    .res       (heat_res)
  );

  // output register frees up when its result is taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // next state for an update or a zero crossing
  always_comb begin
    pump_accum_nxt = pump_accum_r;
    heat_accum_nxt = heat_accum_r;
    pump_set_nxt   = pump_set_r;
    heat_set_nxt   = heat_set_r;
    fires_nxt      = fires_r;
    pump_pin_nxt   = pump_pin_r;
    heat_pin_nxt   = heat_pin_r;
    if (in_kind == dpsm_pkg::KIND_UPDATE) begin
      if (in_clear_count) begin
        fires_nxt = '0;
      end
      pump_set_nxt = (in_pump_level > cfg.mod_range) ? cfg.mod_range : in_pump_level;
      if ((in_heater_temp > cfg.temp_limit) || (in_heater_temp == cfg.sensor_err)) begin
        heat_set_nxt = '0;
      end else begin
        heat_set_nxt = in_heater_level;
      end
    end else begin
      pump_accum_nxt = pump_res.accum;
      heat_accum_nxt = heat_res.accum;
      pump_pin_nxt   = pump_res.skip;
      heat_pin_nxt   = heat_res.skip;
      if (!pump_res.skip) begin
        fires_nxt = fires_r + 1'b1;
      end
    end
  end

  // modulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_accum_r <= '0;
      heat_accum_r <= '0;
      pump_set_r   <= '0;
      heat_set_r   <= '0;
      fires_r      <= '0;
      pump_pin_r   <= 1'b1;
      heat_pin_r   <= 1'b1;
    end else if (accept) begin
      pump_accum_r <= pump_accum_nxt;
      heat_accum_r <= heat_accum_nxt;
      pump_set_r   <= pump_set_nxt;
      heat_set_r   <= heat_set_nxt;
      fires_r      <= fires_nxt;
      pump_pin_r   <= pump_pin_nxt;
      heat_pin_r   <= heat_pin_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pump_r  <= pump_pin_nxt;
      out_heat_r  <= heat_pin_nxt;
      out_count_r <= fires_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pump_skip       = out_pump_r;
  assign out_heater_skip     = out_heat_r;
  assign out_pump_fire_count = out_count_r;

  // every accepted request leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // a pump firing advances the counter by one
  a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == dpsm_pkg::KIND_ZERO_CROSS) && !pump_res.skip)
    |=> (fires_r == $past(fires_r) + 1'b1))
    else $error("pump firing did not advance the counter");

  // updates leave the drive pins alone
  a_update_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == dpsm_pkg::KIND_UPDATE))
    |=> ($stable(pump_pin_r) && $stable(heat_pin_r)))
    else $error("update request changed a drive pin");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result register valid after reset");

endmodule
